// ===== sv/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned PosW      = 7;
  localparam int unsigned ValW      = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CntOutW   = 7;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 48;

  typedef enum logic [OpW-1:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_RETRIEVE = 3'd2,
    OP_REPLACE  = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_READ,
    S_READ_DATA,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== sv/positional_list_engine.sv =====
// Positional list engine: ordered list of values kept in one RAM, edited by position.
//
// Requests enter on the s_axis channel, one result per request leaves on m_axis.
// A request is one of insert, remove, retrieve, replace or clear at a list position.
// The list lives in a one-read/one-write RAM with registered read data; the list
// length lives in a register.
// Throughput: one request at a time. Insert and remove shift the entries from the
// position to the end of the list by one place, since the RAM port shifts one entry
// per cycle; an insert that appends at the end writes at once. Retrieve reads the
// RAM through its read register; replace, clear and failed requests go straight to
// the result state. The last state of each request loads the output register, and
// s_axis_tready returns in the same cycle that m_axis_tvalid rises.
// The next request is taken once the result sits in the output register, so a
// stalled receiver holds at most one result there; a second finished result waits
// inside the block and blocks further requests until m_axis_tready frees the slot.
// Reset empties the list at once (count to zero, no RAM sweep) and drops any
// pending result; RAM contents are undefined until written.
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // op[2:0], position[9:3], value_in[41:10], zero[47:42]
  input  wire logic [ple_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // status[1:0], value_out[33:2], entry_count[40:34], is_empty[41], zero[47:42]
  output logic      [ple_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > ple_pkg::PosW) ? CW : ple_pkg::PosW;

  // Input unpacking
  logic [ple_pkg::OpW-1:0]  in_op;
  logic [ple_pkg::PosW-1:0] in_pos;
  logic [ple_pkg::ValW-1:0] in_val;
  logic [DATA_WIDTH-1:0]    in_val_st;
  logic [CMPW-1:0]          in_pos_ext;
  logic [CMPW-1:0]          count_ext;

  assign in_op      = s_axis_tdata[2:0];
  assign in_pos     = s_axis_tdata[9:3];
  assign in_val     = s_axis_tdata[41:10];
  assign in_pos_ext = CMPW'(in_pos);

  // RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [ple_pkg::ValW-1:0] rdata_out;

  generate
    if (DATA_WIDTH >= ple_pkg::ValW) begin : g_wide
      assign in_val_st = DATA_WIDTH'(in_val);
      assign rdata_out = ram_rdata[ple_pkg::ValW-1:0];
    end else begin : g_narrow
      assign in_val_st = in_val[DATA_WIDTH-1:0];
      assign rdata_out = ple_pkg::ValW'(ram_rdata);
    end
  endgenerate

  ple_ram #(
    .Width(DATA_WIDTH),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // State
  ple_pkg::state_e          state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            cur_q, cur_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [CW-1:0]            prev_q, prev_d;
  logic                     pend_q, pend_d;
  logic [DATA_WIDTH-1:0]    val_q, val_d;
  ple_pkg::status_e         status_q, status_d;
  logic [ple_pkg::ValW-1:0] vout_q, vout_d;
  logic                     out_valid_q, out_valid_d;
  logic [ple_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [ple_pkg::ValW-1:0]    out_value_q, out_value_d;
  logic [ple_pkg::CntOutW-1:0] out_count_q, out_count_d;
  logic                        out_empty_q, out_empty_d;

  logic          out_free;
  logic          accept;
  logic [CW-1:0] wa_full;
  logic [CW-1:0] ra_full;

  assign count_ext     = CMPW'(count_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ple_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ram_waddr     = wa_full[AW-1:0];
  assign ram_raddr     = ra_full[AW-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cur_d        = cur_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    pend_d       = pend_q;
    val_d        = val_q;
    status_d     = status_q;
    vout_d       = vout_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    ram_we       = 1'b0;
    wa_full      = '0;
    ram_wdata    = val_q;
    ram_re       = 1'b0;
    ra_full      = '0;

    unique case (state_q)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          pos_d    = in_pos_ext[CW-1:0];
          val_d    = in_val_st;
          vout_d   = '0;
          status_d = ple_pkg::ST_OK;
          pend_d   = 1'b0;
          state_d  = ple_pkg::S_RESP;
          unique case (in_op)
            ple_pkg::OP_INSERT: begin
              if (in_pos_ext > count_ext) begin
                status_d = ple_pkg::ST_RANGE;
              end else if (count_q == CW'(CAPACITY)) begin
                status_d = ple_pkg::ST_FULL;
              end else begin
                cur_d   = count_q;
                state_d = ple_pkg::S_INSERT;
              end
            end
            ple_pkg::OP_REMOVE: begin
              if (in_pos_ext >= count_ext) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                cur_d   = in_pos_ext[CW-1:0];
                state_d = ple_pkg::S_REMOVE;
              end
            end
            ple_pkg::OP_RETRIEVE: begin
              if (in_pos_ext >= count_ext) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                state_d = ple_pkg::S_READ;
              end
            end
            ple_pkg::OP_REPLACE: begin
              if (in_pos_ext >= count_ext) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                wa_full   = in_pos_ext[CW-1:0];
                ram_wdata = in_val_st;
              end
            end
            ple_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              status_d = ple_pkg::ST_RANGE;
            end
          endcase
        end
      end

      // Shift up: read entry cur-1, write it to cur in the following cycle.
      ple_pkg::S_INSERT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          wa_full   = prev_q;
          ram_wdata = ram_rdata;
        end
        if (cur_q > pos_q) begin
          ram_re  = 1'b1;
          ra_full = cur_q - CW'(1);
          pend_d  = 1'b1;
          prev_d  = cur_q;
          cur_d   = cur_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            ram_we    = 1'b1;
            wa_full   = pos_q;
            ram_wdata = val_q;
            count_d   = count_q + CW'(1);
            state_d   = ple_pkg::S_RESP;
          end
        end
      end

      // Shift down: read entry cur, write it to cur-1; the first read is the removed value.
      ple_pkg::S_REMOVE: begin
        if (pend_q) begin
          if (prev_q == pos_q) begin
            vout_d = rdata_out;
          end else begin
            ram_we    = 1'b1;
            wa_full   = prev_q - CW'(1);
            ram_wdata = ram_rdata;
          end
        end
        if (cur_q < count_q) begin
          ram_re  = 1'b1;
          ra_full = cur_q;
          pend_d  = 1'b1;
          prev_d  = cur_q;
          cur_d   = cur_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CW'(1);
            state_d = ple_pkg::S_RESP;
          end
        end
      end

      ple_pkg::S_READ: begin
        ram_re  = 1'b1;
        ra_full = pos_q;
        state_d = ple_pkg::S_READ_DATA;
      end

      ple_pkg::S_READ_DATA: begin
        vout_d  = rdata_out;
        state_d = ple_pkg::S_RESP;
      end

      ple_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = vout_q;
          out_count_d  = count_ext[ple_pkg::CntOutW-1:0];
          out_empty_d  = (count_q == '0);
          state_d      = ple_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    pos_q        <= pos_d;
    prev_q       <= prev_d;
    val_q        <= val_d;
    status_q     <= status_d;
    vout_q       <= vout_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_empty_q, out_count_q, out_value_q, out_status_q};

endmodule

`default_nettype wire

// ===== sv/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ple_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the positional list engine: random list edits against a shadow list.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned RandomReqs = 1150;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned MaxPrinted = 40;
  localparam int unsigned SendSide   = 0;
  localparam int unsigned RecvSide   = 1;

  typedef struct packed {
    logic [ple_pkg::OpW-1:0]  op;
    logic [ple_pkg::PosW-1:0] position;
    logic [ple_pkg::ValW-1:0] value;
  } list_request_t;

  typedef struct {
    ple_pkg::status_e            status;
    logic [ple_pkg::ValW-1:0]    value;
    logic [ple_pkg::CntOutW-1:0] count;
    logic                        empty;
  } list_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [ple_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [ple_pkg::OutDataW-1:0] m_axis_tdata;

  positional_list_engine #(
    .CAPACITY  (Capacity),
    .DATA_WIDTH(ple_pkg::ValW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Shadow list and bookkeeping
  logic [ple_pkg::ValW-1:0] list_mem [Capacity];
  int              list_fill = 0;
  int              list_peak = 0;

  list_request_t   pending_requests[$];
  list_result_t    awaited_results[$];
  int              plan_fill = 0;

  int   error_count = 0;
  int   results_seen = 0;
  int   requests_taken = 0;
  int   cycle_count = 0;
  int   op_seen [8];
  int   status_seen [3];
  int   calm_left [2];
  int   send_wait = 0;
  int   recv_wait = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic rx_hold = 1'b0;

  // Apply one request to the shadow list and return the result it must produce.
  function automatic list_result_t apply_request(list_request_t req);
    list_result_t res;
    int idx;
    res.status = ple_pkg::ST_OK;
    res.value  = '0;
    case (req.op)
      ple_pkg::OP_INSERT: begin
        if (req.position > list_fill) begin
          res.status = ple_pkg::ST_RANGE;
        end else if (list_fill >= Capacity) begin
          res.status = ple_pkg::ST_FULL;
        end else begin
          for (idx = list_fill; idx > req.position; idx--) list_mem[idx] = list_mem[idx-1];
          list_mem[req.position] = req.value;
          list_fill++;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (req.position >= list_fill) begin
          res.status = ple_pkg::ST_RANGE;
        end else begin
          res.value = list_mem[req.position];
          for (idx = req.position; idx + 1 < list_fill; idx++) list_mem[idx] = list_mem[idx+1];
          list_fill--;
        end
      end
      ple_pkg::OP_RETRIEVE: begin
        if (req.position >= list_fill) res.status = ple_pkg::ST_RANGE;
        else res.value = list_mem[req.position];
      end
      ple_pkg::OP_REPLACE: begin
        if (req.position >= list_fill) res.status = ple_pkg::ST_RANGE;
        else list_mem[req.position] = req.value;
      end
      ple_pkg::OP_CLEAR: begin
        list_fill = 0;
      end
      default: begin
        res.status = ple_pkg::ST_RANGE;
      end
    endcase
    res.count = ple_pkg::CntOutW'(list_fill);
    res.empty = (list_fill == 0);
    if (list_fill > list_peak) list_peak = list_fill;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ple_pkg::ValW-1:0] got,
                                 logic [ple_pkg::ValW-1:0] want);
    if (error_count < MaxPrinted) begin
      $display("ERROR @%0t result %0d %s: got 0x%08h, expected 0x%08h",
               $realtime, results_seen, what, got, want);
    end
    error_count++;
  endtask

  function automatic int draw_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [ple_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Queue a request and track the list length it leads to, so later requests can aim at
  // valid positions.
  task automatic queue_request(logic [ple_pkg::OpW-1:0] op, int pos,
                               logic [ple_pkg::ValW-1:0] value);
    list_request_t req;
    req.op       = op;
    req.position = ple_pkg::PosW'(pos);
    req.value    = value;
    pending_requests.push_back(req);
    case (op)
      ple_pkg::OP_INSERT: if (pos <= plan_fill && plan_fill < Capacity) plan_fill++;
      ple_pkg::OP_REMOVE: if (pos < plan_fill) plan_fill--;
      ple_pkg::OP_CLEAR:  plan_fill = 0;
      default:   ;
    endcase
  endtask

  task automatic queue_directed();
    int code;
    queue_request(ple_pkg::OP_RETRIEVE, 0, 32'h1234_5678);
    queue_request(ple_pkg::OP_REMOVE, 0, '0);
    queue_request(ple_pkg::OP_REPLACE, 0, 32'hDEAD_BEEF);
    queue_request(ple_pkg::OP_INSERT, 1, 32'h0BAD_F00D);
    queue_request(ple_pkg::OP_INSERT, (1 << ple_pkg::PosW) - 1, 32'h0000_0001);
    for (code = int'(ple_pkg::OP_CLEAR) + 1; code < (1 << ple_pkg::OpW); code++) begin
      queue_request(ple_pkg::OpW'(code), $urandom_range(0, 3), $urandom);
    end
    queue_request(ple_pkg::OP_CLEAR, 0, '0);
    queue_request(ple_pkg::OP_INSERT, 0, 32'h8000_0000);
    queue_request(ple_pkg::OP_INSERT, 0, 32'h7FFF_FFFF);
    queue_request(ple_pkg::OP_INSERT, 2, 32'hFFFF_FFFF);
    queue_request(ple_pkg::OP_INSERT, 1, 32'h0000_0000);
    queue_request(ple_pkg::OP_INSERT, (1 << ple_pkg::PosW) - 1, 32'hAAAA_AAAA);
    for (code = 0; code < 4; code++) queue_request(ple_pkg::OP_RETRIEVE, code, '0);
    queue_request(ple_pkg::OP_REPLACE, 3, 32'h5555_5555);
    queue_request(ple_pkg::OP_REPLACE, 4, 32'hAAAA_AAAA);
    queue_request(ple_pkg::OP_REMOVE, 4, '0);
    queue_request(ple_pkg::OP_REMOVE, 1, '0);
    queue_request(ple_pkg::OP_REMOVE, 0, '0);
    queue_request(ple_pkg::OP_RETRIEVE, 1, '0);
    queue_request(ple_pkg::OP_CLEAR, (1 << ple_pkg::PosW) - 1, 32'hFFFF_FFFF);
    queue_request(ple_pkg::OP_RETRIEVE, 0, '0);
  endtask

  // Mostly well-aimed edits at valid positions; the rest is any code at any position.
  task automatic queue_mixed();
    int pick;
    int pos;
    logic [ple_pkg::OpW-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      op  = ple_pkg::OpW'($urandom_range(0, (1 << ple_pkg::OpW) - 1));
      pos = $urandom_range(0, (1 << ple_pkg::PosW) - 1);
    end else if (pick < 14) begin
      op  = ple_pkg::OP_CLEAR;
      pos = $urandom_range(0, (1 << ple_pkg::PosW) - 1);
    end else begin
      case ($urandom_range(0, 4))
        0, 1:    op = ple_pkg::OP_INSERT;
        2:       op = ple_pkg::OP_REMOVE;
        3:       op = ple_pkg::OP_RETRIEVE;
        default: op = ple_pkg::OP_REPLACE;
      endcase
      if (op != ple_pkg::OP_INSERT && plan_fill == 0) op = ple_pkg::OP_INSERT;
      if (op == ple_pkg::OP_INSERT) pos = $urandom_range(0, plan_fill);
      else pos = $urandom_range(0, plan_fill - 1);
    end
    queue_request(op, pos, pick_value());
  endtask

  task automatic queue_random(int total);
    int n;
    int pos;
    while (pending_requests.size() < total) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill to capacity, then push against the full list
          while (plan_fill < Capacity) begin
            case ($urandom_range(0, 3))
              0:       pos = 0;
              1:       pos = plan_fill;
              default: pos = $urandom_range(0, plan_fill);
            endcase
            queue_request(ple_pkg::OP_INSERT, pos, pick_value());
          end
          n = $urandom_range(2, 5);
          repeat (n) queue_request(ple_pkg::OP_INSERT,
                                   $urandom_range(0, (1 << ple_pkg::PosW) - 1), $urandom);
        end
        2: begin
          while (plan_fill > 0) begin
            case ($urandom_range(0, 3))
              0:       pos = 0;
              1:       pos = plan_fill - 1;
              default: pos = $urandom_range(0, plan_fill - 1);
            endcase
            queue_request(ple_pkg::OP_REMOVE, pos, $urandom);
          end
          queue_request(ple_pkg::OP_REMOVE, $urandom_range(0, (1 << ple_pkg::PosW) - 1),
                        $urandom);
        end
        default: begin
          n = $urandom_range(20, 60);
          repeat (n) queue_mixed();
        end
      endcase
    end
  endtask

  // Sample handshakes, predict on each input transfer and check each output transfer.
  always @(posedge clk_i) begin
    list_request_t req;
    list_result_t  want;
    cycle_count++;
    if (rst_ni) begin
      in_taken  = s_axis_tvalid && s_axis_tready;
      out_taken = m_axis_tvalid && m_axis_tready;
      if (in_taken) begin
        req.op       = s_axis_tdata[ple_pkg::OpW-1:0];
        req.position = s_axis_tdata[ple_pkg::OpW +: ple_pkg::PosW];
        req.value    = s_axis_tdata[ple_pkg::OpW+ple_pkg::PosW +: ple_pkg::ValW];
        want = apply_request(req);
        awaited_results.push_back(want);
        op_seen[req.op]++;
        status_seen[want.status]++;
        requests_taken++;
      end
      if (out_taken) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("arrived with no request pending",
                          m_axis_tdata[ple_pkg::ValW-1:0], '0);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata[ple_pkg::StatusW-1:0] != want.status)
            report_mismatch("status", ple_pkg::ValW'(m_axis_tdata[ple_pkg::StatusW-1:0]),
                            ple_pkg::ValW'(want.status));
          if (m_axis_tdata[ple_pkg::StatusW +: ple_pkg::ValW] != want.value)
            report_mismatch("value_out", m_axis_tdata[ple_pkg::StatusW +: ple_pkg::ValW],
                            want.value);
          if (m_axis_tdata[ple_pkg::StatusW+ple_pkg::ValW +: ple_pkg::CntOutW] != want.count)
            report_mismatch("entry_count",
              ple_pkg::ValW'(m_axis_tdata[ple_pkg::StatusW+ple_pkg::ValW +: ple_pkg::CntOutW]),
              ple_pkg::ValW'(want.count));
          if (m_axis_tdata[ple_pkg::StatusW+ple_pkg::ValW+ple_pkg::CntOutW] != want.empty)
            report_mismatch("is_empty",
              ple_pkg::ValW'(m_axis_tdata[ple_pkg::StatusW+ple_pkg::ValW+ple_pkg::CntOutW]),
              ple_pkg::ValW'(want.empty));
          if (m_axis_tdata[ple_pkg::OutDataW-1:
                           ple_pkg::StatusW+ple_pkg::ValW+ple_pkg::CntOutW+1] != '0)
            report_mismatch("padding",
              ple_pkg::ValW'(m_axis_tdata[ple_pkg::OutDataW-1:
                                          ple_pkg::StatusW+ple_pkg::ValW+ple_pkg::CntOutW+1]),
              '0);
        end
        results_seen++;
      end
    end
  end

  // Request driver: advance only after a transfer or while idle.
  always @(negedge clk_i) begin
    list_request_t req;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        req = pending_requests.pop_front();
        s_axis_tdata  <= ple_pkg::InDataW'({req.value, req.position, req.op});
        s_axis_tvalid <= 1'b1;
        send_wait = draw_gap(SendSide);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall each result for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) recv_wait = draw_gap(RecvSide);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        m_axis_tready <= 1'b0;
        if (m_axis_tvalid) recv_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hold off the receiver long enough that the engine backs up and stops taking requests.
  initial begin
    wait (requests_taken >= HoldAfter);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, awaited_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    list_result_t left;
    int           total_reqs;
    queue_directed();
    queue_random(pending_requests.size() + RandomReqs);
    total_reqs = pending_requests.size();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (requests_taken < total_reqs || awaited_results.size() > 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    while (awaited_results.size() > 0) begin
      left = awaited_results.pop_front();
      report_mismatch("never arrived", '0, left.value);
    end
    $display("Covered %0d requests (ins %0d, rem %0d, get %0d, rep %0d, clr %0d, unused %0d)",
             requests_taken, op_seen[ple_pkg::OP_INSERT], op_seen[ple_pkg::OP_REMOVE],
             op_seen[ple_pkg::OP_RETRIEVE], op_seen[ple_pkg::OP_REPLACE],
             op_seen[ple_pkg::OP_CLEAR], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("Outcomes: %0d success, %0d out of range, %0d list full; longest list %0d",
             status_seen[ple_pkg::ST_OK], status_seen[ple_pkg::ST_RANGE],
             status_seen[ple_pkg::ST_FULL], list_peak);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
